@@ sv/handheld_bus_decoder_sysregs_unit_assert.svh @@
// assertion macros for the bus decoder top level
// depends on nothing; included by the top level only
`ifndef HANDHELD_BUS_DECODER_SYSREGS_UNIT_ASSERT_SVH
`define HANDHELD_BUS_DECODER_SYSREGS_UNIT_ASSERT_SVH
// check that holds in the cycle after a condition
`define HBD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
// check that holds in the same cycle
`define HBD_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`endif

@@ sv/hbd_pkg.sv @@
// package of the bus decoder: types, codes and constants
// no dependencies
package hbd_pkg;
  localparam int BANK_BYTES_DEF = 4096;
  localparam int BANK_COUNT_DEF = 8;
  localparam int HRAM_BYTES     = 127;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [2:0] {
    REQ_CPU_RD = 3'd0, REQ_CPU_WR = 3'd1, REQ_DMA_RD = 3'd2, REQ_DMA_WR = 3'd3,
    REQ_IRQ_SET = 3'd4, REQ_IRQ_CLR = 3'd5, REQ_IRQ_POLL = 3'd6, REQ_SPEED = 3'd7
  } req_t;

  typedef enum logic [3:0] {
    TGT_LOCAL = 4'd0, TGT_CART = 4'd1, TGT_VRAM = 4'd2, TGT_OAM = 4'd3,
    TGT_VIDEO = 4'd4, TGT_AUDIO = 4'd5, TGT_TIMER = 4'd6, TGT_OAMDMA = 4'd7,
    TGT_CDMA = 4'd8, TGT_CVIDEO = 4'd9
  } tgt_t;

  // what the back end does with a request
  typedef enum logic [3:0] {
    OP_NONE, OP_WRAM_RD, OP_WRAM_WR, OP_HRAM_RD, OP_HRAM_WR, OP_CONST,
    OP_JOYPAD, OP_IE_RD, OP_IE_WR, OP_IF_RD, OP_IF_WR, OP_KEY_WR,
    OP_SPD_RD, OP_SPD_WR, OP_BANK_RD, OP_BANK_WR
  } op_t;

  typedef struct packed {
    req_t       kind;
    op_t        op;
    tgt_t       tgt;
    logic [15:0] addr;
    logic [7:0] wdata;
    logic [4:0] irq_bits;
    logic [7:0] buttons;
    logic [7:0] cdata;
  } cmd_t;
endpackage

@@ sv/hbd_chan_if.sv @@
// valid/ready channel interface carrying a packed payload
// depends on nothing
interface hbd_chan_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/hbd_front.sv @@
// front end: classifies a request into a back-end command
// depends on hbd_pkg
module hbd_front import hbd_pkg::*; (
  input  logic        color_mode,
  input  logic [2:0]  req_type,
  input  logic [15:0] bus_addr,
  input  logic [7:0]  write_data,
  input  logic [4:0]  irq_bits,
  input  logic [7:0]  buttons,
  output cmd_t        cmd
);
  logic [15:0] a;
  logic        rd, is_reg;
  assign a = bus_addr;

  always_comb begin
    rd = (req_type == REQ_CPU_RD);
    is_reg = (a >= 16'h8000 && a <= 16'h9FFF) || a >= 16'hFE00;
    cmd.kind = req_t'(req_type);
    cmd.addr = a;
    cmd.wdata = write_data;
    cmd.irq_bits = irq_bits;
    cmd.buttons = buttons;
    cmd.op = OP_NONE;
    cmd.tgt = TGT_LOCAL;
    cmd.cdata = 8'h00;
    case (req_t'(req_type))
      REQ_CPU_RD, REQ_CPU_WR: begin
        if (!is_reg) begin
          if (a >= 16'hC000) cmd.op = rd ? OP_WRAM_RD : OP_WRAM_WR;
          else cmd.tgt = TGT_CART;
        end else if (a < 16'hFE00) begin
          cmd.tgt = TGT_VRAM;
        end else if (a < 16'hFF00) begin
          cmd.tgt = TGT_OAM;
        end else if (a == 16'hFFFF) begin
          cmd.op = rd ? OP_IE_RD : OP_IE_WR;
        end else if (a == 16'hFF46) begin
          cmd.tgt = TGT_OAMDMA;
        end else if (a >= 16'hFF80) begin
          cmd.op = rd ? OP_HRAM_RD : OP_HRAM_WR;
        end else if (a >= 16'hFF4D) begin
          if (rd) begin
            cmd.op = OP_CONST;
            cmd.cdata = 8'hFF;
          end
          if (color_mode && !(!rd && a == 16'hFF50)) begin
            if (a == 16'hFF4D) cmd.op = rd ? OP_SPD_RD : OP_SPD_WR;
            else if (a >= 16'hFF51 && a <= 16'hFF55) begin
              cmd.tgt = TGT_CDMA;
              cmd.op = OP_NONE;
            end else if (a == 16'hFF4F || (a >= 16'hFF68 && a <= 16'hFF6B)) begin
              cmd.tgt = TGT_CVIDEO;
              cmd.op = OP_NONE;
            end else if (a == 16'hFF70) cmd.op = rd ? OP_BANK_RD : OP_BANK_WR;
          end
        end else if (a >= 16'hFF40) begin
          cmd.tgt = TGT_VIDEO;
        end else if (a >= 16'hFF10) begin
          cmd.tgt = TGT_AUDIO;
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
          cmd.tgt = TGT_TIMER;
        end else if (a == 16'hFF00) begin
          cmd.op = rd ? OP_JOYPAD : OP_KEY_WR;
        end else if (a == 16'hFF0F) begin
          cmd.op = rd ? OP_IF_RD : OP_IF_WR;
        end else if (rd) begin
          cmd.op = OP_CONST;
          cmd.cdata = (a == 16'hFF01) ? 8'h00 : (a == 16'hFF02) ? 8'h7E : 8'hFF;
        end
      end
      REQ_DMA_RD: begin
        if (a >= 16'hC000) cmd.op = OP_WRAM_RD;
        else if (a >= 16'h8000 && a <= 16'h9FFF) cmd.tgt = TGT_VRAM;
        else cmd.tgt = TGT_CART;
      end
      REQ_DMA_WR: cmd.tgt = TGT_OAM;
      default: cmd.op = OP_NONE;
    endcase
  end
endmodule

@@ sv/hbd_queue.sv @@
// short request queue between front and back end
// depends on hbd_pkg
module hbd_queue import hbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);
  cmd_t       mem_r [QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'(QUEUE_DEPTH));
  assign out_valid = (cnt_r != 2'd0);
  assign out_cmd   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ sv/hbd_back.sv @@
// back end: registers, memories and the result stage
// depends on hbd_pkg
module hbd_back import hbd_pkg::*; #(
  parameter int BANK_BYTES = BANK_BYTES_DEF,
  parameter int BANK_COUNT = BANK_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] read_data,
  output logic [3:0] target,
  output logic [4:0] irq_taken,
  output logic       high_speed,
  output logic       speed_request
);
  localparam int OFF_W  = $clog2(BANK_BYTES);
  localparam int BSEL_W = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int WR_W   = $clog2(BANK_COUNT * BANK_BYTES);

  logic [7:0] wram_r [BANK_COUNT * BANK_BYTES];
  logic [7:0] hram_r [HRAM_BYTES];
  logic [7:0] ie_r, key_r;
  logic [4:0] if_r, if_nxt;
  logic [2:0] bank_r;
  logic       spd_r, pend_r, spd_nxt, pend_nxt;

  // output stage: memory read data is registered alongside the other results
  logic       v_r;
  logic       mrd_r, hsel_r;
  logic [7:0] d_r, wq_r, hq_r;
  logic [3:0] t_r;
  logic [4:0] tk_r;
  logic       hs_r, sr_r;

  logic             adv;
  logic [BSEL_W-1:0] bsel;
  logic [BSEL_W-1:0] bank_mod [8];
  logic [WR_W-1:0]  widx;
  logic [6:0]       hidx, hlow;
  logic [4:0]       pend_irq;
  logic [7:0]       data_nxt, joy;
  logic [3:0]       jl;
  logic [2:0]       wb;

  assign adv = !v_r || res_ready;
  assign cmd_ready = adv;

  // bank number modulo bank count, a constant table
  for (genvar g = 0; g < 8; g++) begin : g_bank_mod
    assign bank_mod[g] = BSEL_W'(g % BANK_COUNT);
  end

  always_comb begin
    bsel = cmd.addr[12] ? bank_mod[bank_r] : '0;
    widx = WR_W'({bsel, cmd.addr[OFF_W-1:0]});
    hlow = cmd.addr[6:0];
    hidx = (hlow == 7'h7F) ? 7'h00 : hlow;
    pend_irq = if_r & ie_r[4:0];
    jl = 4'hF;
    if (!key_r[5]) jl = jl & ~cmd.buttons[3:0];
    if (!key_r[4]) jl = jl & ~cmd.buttons[7:4];
    joy = {2'b11, key_r[5:4], jl};
    wb = (cmd.wdata[2:0] == 3'd0) ? 3'd1 : cmd.wdata[2:0];
    if_nxt = if_r;
    spd_nxt = spd_r;
    pend_nxt = pend_r;
    data_nxt = 8'h00;
    case (cmd.op)
      OP_CONST:   data_nxt = cmd.cdata;
      OP_JOYPAD:  data_nxt = joy;
      OP_IE_RD:   data_nxt = ie_r;
      OP_IF_RD:   data_nxt = {3'b111, if_r};
      OP_IF_WR:   if_nxt = cmd.wdata[4:0];
      OP_SPD_RD:  data_nxt = {spd_r, 7'h00};
      OP_SPD_WR:  pend_nxt = cmd.wdata[0];
      OP_BANK_RD: data_nxt = {5'h00, bank_r};
      default:    data_nxt = 8'h00;
    endcase
    case (cmd.kind)
      REQ_IRQ_SET: if_nxt = if_r | cmd.irq_bits;
      REQ_IRQ_CLR: if_nxt = if_r & ~cmd.irq_bits;
      REQ_SPEED: begin
        pend_nxt = 1'b0;
        spd_nxt = ~spd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && adv) begin
      if (cmd.op == OP_WRAM_WR) wram_r[widx] <= cmd.wdata;
      if (cmd.op == OP_HRAM_WR) hram_r[hidx] <= cmd.wdata;
      wq_r <= wram_r[widx];
      hq_r <= hram_r[hidx];
      mrd_r <= (cmd.op == OP_WRAM_RD) || (cmd.op == OP_HRAM_RD);
      hsel_r <= (cmd.op == OP_HRAM_RD);
      d_r <= data_nxt;
      t_r <= cmd.tgt;
      tk_r <= (cmd.kind == REQ_IRQ_POLL) ? (pend_irq & (~pend_irq + 5'd1)) : 5'd0;
      hs_r <= spd_nxt;
      sr_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      ie_r <= 8'h00;
      if_r <= 5'h00;
      key_r <= 8'h00;
      bank_r <= 3'd1;
      spd_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (adv) v_r <= cmd_valid;
      if (cmd_valid && adv) begin
        if_r <= if_nxt;
        spd_r <= spd_nxt;
        pend_r <= pend_nxt;
        if (cmd.op == OP_IE_WR) ie_r <= cmd.wdata;
        if (cmd.op == OP_KEY_WR) key_r <= cmd.wdata;
        if (cmd.op == OP_BANK_WR) bank_r <= wb;
      end
    end
  end

  assign res_valid = v_r;
  assign read_data = mrd_r ? (hsel_r ? hq_r : wq_r) : d_r;
  assign target = t_r;
  assign irq_taken = tk_r;
  assign high_speed = hs_r;
  assign speed_request = sr_r;
endmodule

@@ sv/handheld_bus_decoder_sysregs_unit.sv @@
// path: a request passes through a queue slot and then the back-end output register
// throughput: one request per clock; queue and output register let both sides stall
// the back end executes in order, so reads see every earlier write
// reset: rst_n synchronous active low clears queue, result valid and system registers (bank register resets to 1)
// work ram and high ram are not cleared; no clearing pass
// config write (color_mode) is taken at once whenever cfg_valid is high
module handheld_bus_decoder_sysregs_unit import hbd_pkg::*; #(
  parameter int BANK_BYTES = BANK_BYTES_DEF,
  parameter int BANK_COUNT = BANK_COUNT_DEF
) (
  input logic clk,
  input logic rst_n,
  hbd_chan_if.sink   in_ch,
  hbd_chan_if.source out_ch,
  hbd_chan_if.sink   cfg_ch
);
  `include "handheld_bus_decoder_sysregs_unit_assert.svh"

  logic color_mode_r;
  cmd_t fcmd, qcmd;
  logic q_valid, q_ready;

  // config register, always ready
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) color_mode_r <= 1'b0;
    else if (cfg_ch.valid) color_mode_r <= cfg_ch.data[0];
  end

  // front: classify the incoming request
  hbd_front u_front (
    .color_mode (color_mode_r),
    .req_type   (in_ch.data[39:37]),
    .bus_addr   (in_ch.data[36:21]),
    .write_data (in_ch.data[20:13]),
    .irq_bits   (in_ch.data[12:8]),
    .buttons    (in_ch.data[7:0]),
    .cmd        (fcmd)
  );

  // decoupling queue
  hbd_queue u_queue (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_cmd (fcmd),
    .out_valid (q_valid), .out_ready (q_ready), .out_cmd (qcmd)
  );

  // back: execute and hold the result
  hbd_back #(.BANK_BYTES(BANK_BYTES), .BANK_COUNT(BANK_COUNT)) u_back (
    .clk, .rst_n,
    .cmd_valid (q_valid), .cmd_ready (q_ready), .cmd (qcmd),
    .res_valid (out_ch.valid), .res_ready (out_ch.ready),
    .read_data (out_ch.data[18:11]),
    .target    (out_ch.data[10:7]),
    .irq_taken (out_ch.data[6:2]),
    .high_speed (out_ch.data[1]),
    .speed_request (out_ch.data[0])
  );

  `HBD_ASSERT_NOW(a_taken_onehot, out_ch.valid, $onehot0(out_ch.data[6:2]), "irq_taken not one-hot")
  `HBD_ASSERT_NOW(a_target_range, out_ch.valid, out_ch.data[10:7] <= 4'd9, "target out of range")
  `HBD_ASSERT_NEXT(a_res_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
endmodule
